// ===== rtl/three_axis_attitude_pid_unit_defines.svh =====
// Assertion macros for the three-axis attitude PID unit.
`ifndef THREE_AXIS_ATTITUDE_PID_UNIT_DEFINES_SVH
`define THREE_AXIS_ATTITUDE_PID_UNIT_DEFINES_SVH

// checked outside reset
`define TAPID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked during reset too
`define TAPID_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tapid_pkg.sv =====
// Shared types, register indexes and sequencer commands for the attitude PID unit.
package tapid_pkg;

	typedef logic [4:0] op_t;

	localparam op_t OP_IDLE   = 5'd0;
	localparam op_t OP_NINIT  = 5'd1;
	localparam op_t OP_SQ     = 5'd2;
	localparam op_t OP_SQW    = 5'd3;
	localparam op_t OP_CINIT  = 5'd4;
	localparam op_t OP_CBIT   = 5'd5;
	localparam op_t OP_CSTORE = 5'd6;
	localparam op_t OP_EMUL   = 5'd7;
	localparam op_t OP_EAX    = 5'd8;
	localparam op_t OP_IMUL   = 5'd9;
	localparam op_t OP_IUPD   = 5'd10;
	localparam op_t OP_PMUL   = 5'd11;
	localparam op_t OP_PACC   = 5'd12;
	localparam op_t OP_GMUL   = 5'd13;
	localparam op_t OP_GACC   = 5'd14;
	localparam op_t OP_DMUL   = 5'd15;
	localparam op_t OP_MSAVE  = 5'd16;
	localparam op_t OP_RMUL0  = 5'd17;
	localparam op_t OP_RACC0  = 5'd18;
	localparam op_t OP_RMUL1  = 5'd19;
	localparam op_t OP_RACC1  = 5'd20;
	localparam op_t OP_DOUT   = 5'd21;
	localparam op_t OP_OUT    = 5'd22;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_TARGET_X    = 3'd0;
	localparam reg_idx_t REG_TARGET_Y    = 3'd1;
	localparam reg_idx_t REG_TARGET_Z    = 3'd2;
	localparam reg_idx_t REG_GAIN_PROP   = 3'd3;
	localparam reg_idx_t REG_GAIN_INTEG  = 3'd4;
	localparam reg_idx_t REG_GAIN_DERIV  = 3'd5;
	localparam reg_idx_t REG_TICK_LENGTH = 3'd6;
	localparam reg_idx_t REG_TICK_RATE   = 3'd7;

	localparam logic [1:0] LAST_AXIS = 2'd2;
	localparam logic [3:0] TOP_BIT   = 4'd14;

	localparam logic signed [19:0] INTEG_MAX = 20'sd262144;
	localparam logic signed [15:0] DRIVE_MAX = 16'sd20480;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic       vsel;      // 0: target, 1: measured axis
		logic [3:0] bitn;
		logic       load_in;
		logic       load_out;
	} cmd_t;

endpackage

// ===== rtl/tapid_if.sv =====
// Channel interfaces: measured axis in, drive voltages out, register writes.
interface tapid_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] axis_z;
	modport source (output valid, axis_x, axis_y, axis_z, input ready);
	modport sink (input valid, axis_x, axis_y, axis_z, output ready);
endinterface

interface tapid_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] drive_x;
	logic signed [15:0] drive_y;
	logic signed [15:0] drive_z;
	modport source (output valid, drive_x, drive_y, drive_z, input ready);
	modport sink (input valid, drive_x, drive_y, drive_z, output ready);
endinterface

interface tapid_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/three_axis_attitude_pid_unit.sv =====
// Top level of the three-axis attitude PID unit.
// One measured axis in, three drive voltages out, per control tick. Each tick runs
// through one shared 37x25 multiplier and a bit-serial square-root search (15 steps
// per component, six components). The input is taken again as soon as the sequencer
// is idle, while a finished result still waits in the output register. Register writes
// are taken at once, every cycle.
`include "three_axis_attitude_pid_unit_defines.svh"

module three_axis_attitude_pid_unit (
	input  logic        clk,
	input  logic        arst_n,
	tapid_in_if.sink    meas,
	tapid_out_if.source drive,
	tapid_cfg_if.sink   cfg
);
	import tapid_pkg::*;

	cmd_t               cmd;
	logic signed [15:0] axis_in [3];
	logic signed [15:0] drive_val [3];

	assign cfg.ready  = 1'b1;
	assign axis_in[0] = meas.axis_x;
	assign axis_in[1] = meas.axis_y;
	assign axis_in[2] = meas.axis_z;

	tapid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (meas.valid),
		.in_ready  (meas.ready),
		.out_valid (drive.valid),
		.out_ready (drive.ready),
		.cmd       (cmd)
	);

	tapid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.axis_in   (axis_in),
		.drive_val (drive_val)
	);

	assign drive.drive_x = drive_val[0];
	assign drive.drive_y = drive_val[1];
	assign drive.drive_z = drive_val[2];

	`TAPID_ASSERT(a_busy_after_in, (meas.valid && meas.ready) |=> !meas.ready, "input taken while busy")
	`TAPID_ASSERT(a_drive_range, drive.valid |-> (drive.drive_x <= DRIVE_MAX && drive.drive_x >= -DRIVE_MAX && drive.drive_y <= DRIVE_MAX && drive.drive_y >= -DRIVE_MAX && drive.drive_z <= DRIVE_MAX && drive.drive_z >= -DRIVE_MAX), "drive out of range")
	`TAPID_ASSERT_RST(a_reset_quiet, !arst_n |-> (!drive.valid && meas.ready), "output valid in reset")

endmodule

// ===== rtl/tapid_ctrl.sv =====
// Sequencer that steps the shared datapath through one control tick.
module tapid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tapid_pkg::cmd_t  cmd
);
	import tapid_pkg::*;

	op_t        state_q;
	logic [1:0] idx_q;
	logic       vsel_q;
	logic [3:0] bit_q;
	logic       ovalid_q;
	logic       accept;
	logic       emit;

	assign in_ready  = (state_q == OP_IDLE);
	assign accept    = in_valid && in_ready;
	assign emit      = (state_q == OP_OUT) && (!ovalid_q || out_ready);
	assign out_valid = ovalid_q;

	assign cmd.op       = state_q;
	assign cmd.idx      = idx_q;
	assign cmd.vsel     = vsel_q;
	assign cmd.bitn     = bit_q;
	assign cmd.load_in  = accept;
	assign cmd.load_out = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
			idx_q   <= 2'd0;
			vsel_q  <= 1'b0;
			bit_q   <= 4'd0;
		end else begin
			case (state_q)
				OP_IDLE: begin
					if (accept) begin
						state_q <= OP_NINIT;
						vsel_q  <= 1'b0;
						idx_q   <= 2'd0;
					end
				end
				OP_NINIT: state_q <= OP_SQ;
				OP_SQ:    state_q <= OP_SQW;
				OP_SQW: begin
					if (idx_q == LAST_AXIS) begin
						idx_q   <= 2'd0;
						state_q <= OP_CINIT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= OP_SQ;
					end
				end
				OP_CINIT: begin
					bit_q   <= TOP_BIT;
					state_q <= OP_CBIT;
				end
				OP_CBIT: begin
					if (bit_q == 4'd0) begin
						state_q <= OP_CSTORE;
					end else begin
						bit_q <= bit_q - 4'd1;
					end
				end
				OP_CSTORE: begin
					if (idx_q == LAST_AXIS) begin
						idx_q <= 2'd0;
						if (!vsel_q) begin
							vsel_q  <= 1'b1;
							state_q <= OP_NINIT;
						end else begin
							state_q <= OP_EMUL;
						end
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= OP_CINIT;
					end
				end
				OP_EMUL: state_q <= OP_EAX;
				OP_EAX: begin
					if (idx_q == LAST_AXIS) begin
						idx_q   <= 2'd0;
						state_q <= OP_IMUL;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= OP_EMUL;
					end
				end
				OP_IMUL:  state_q <= OP_IUPD;
				OP_IUPD:  state_q <= OP_PMUL;
				OP_PMUL:  state_q <= OP_PACC;
				OP_PACC:  state_q <= OP_GMUL;
				OP_GMUL:  state_q <= OP_GACC;
				OP_GACC:  state_q <= OP_DMUL;
				OP_DMUL:  state_q <= OP_MSAVE;
				OP_MSAVE: state_q <= OP_RMUL0;
				OP_RMUL0: state_q <= OP_RACC0;
				OP_RACC0: state_q <= OP_RMUL1;
				OP_RMUL1: state_q <= OP_RACC1;
				OP_RACC1: state_q <= OP_DOUT;
				OP_DOUT: begin
					if (idx_q == LAST_AXIS) begin
						idx_q   <= 2'd0;
						state_q <= OP_OUT;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= OP_IMUL;
					end
				end
				OP_OUT: begin
					if (emit) begin
						state_q <= OP_IDLE;
					end
				end
				default: state_q <= OP_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/tapid_dp.sv =====
// Datapath: registers, one shared multiplier, square-root search and PID lanes.
module tapid_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tapid_pkg::cmd_t         cmd,
	input  logic                    cfg_we,
	input  tapid_pkg::reg_idx_t     cfg_idx,
	input  logic [23:0]             cfg_data,
	input  logic signed [15:0]      axis_in [3],
	output logic signed [15:0]      drive_val [3]
);
	import tapid_pkg::*;

	logic signed [15:0] tgt_q [3];
	logic [15:0] gp_q, gi_q, gd_q, tl_q;
	logic [23:0] tr_q;
	logic signed [19:0] integ_q [3];
	logic signed [17:0] last_q [3];

	logic signed [15:0] vin_q [3];
	logic [30:0]        sq_q [3];
	logic [31:0]        s_q;
	logic [58:0]        num_q;
	logic [61:0]        p_q;
	logic [47:0]        qs_q;
	logic [14:0]        qv_q;
	logic signed [15:0] tn_q [3];
	logic signed [15:0] cn_q [3];
	logic signed [17:0] ax_q [3];
	logic signed [35:0] m_q;
	logic signed [61:0] prod_q;
	logic signed [61:0] acc_q;
	logic signed [15:0] drv_q [3];
	logic signed [15:0] out_q [3];

	logic signed [15:0] vcur;
	logic signed [16:0] e_v [3];
	logic signed [36:0] mul_a;
	logic signed [24:0] mul_b;
	logic [63:0]        c2s;
	logic               take;
	logic signed [15:0] nval;
	logic signed [61:0] eax_t;
	logic signed [21:0] isum;
	logic signed [19:0] inext;
	logic signed [38:0] dsh;
	logic signed [15:0] dclamp;

	assign vcur = cmd.vsel ? vin_q[cmd.idx] : tgt_q[cmd.idx];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e_v[i] = 17'(tn_q[i]) - 17'(cn_q[i]);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = 37'(vcur);
				mul_b = 25'(vcur);
			end
			OP_EMUL: begin
				case (cmd.idx)
					2'd0: begin
						mul_a = 37'(e_v[1]);
						mul_b = 25'(e_v[2]);
					end
					2'd1: begin
						mul_a = 37'(e_v[2]);
						mul_b = 25'(e_v[0]);
					end
					default: begin
						mul_a = 37'(e_v[0]);
						mul_b = 25'(e_v[1]);
					end
				endcase
			end
			OP_IMUL: begin
				mul_a = 37'(ax_q[cmd.idx]);
				mul_b = {9'd0, tl_q};
			end
			OP_PMUL: begin
				mul_a = 37'(ax_q[cmd.idx]);
				mul_b = {9'd0, gp_q};
			end
			OP_GMUL: begin
				mul_a = 37'(integ_q[cmd.idx]);
				mul_b = {9'd0, gi_q};
			end
			OP_DMUL: begin
				mul_a = 37'(19'(ax_q[cmd.idx]) - 19'(last_q[cmd.idx]));
				mul_b = {9'd0, gd_q};
			end
			OP_RMUL0: begin
				mul_a = 37'(m_q);
				mul_b = {13'd0, tr_q[11:0]};
			end
			OP_RMUL1: begin
				mul_a = 37'(m_q);
				mul_b = {13'd0, tr_q[23:12]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// trial square of the next quotient bit times s, built from running sums
	assign c2s = {2'b00, p_q} + ({16'd0, qs_q} << (cmd.bitn + 4'd1))
		+ ({32'd0, s_q} << {cmd.bitn, 1'b0});
	assign take = (c2s <= {5'd0, num_q});

	assign nval = (s_q == 32'd0) ? vcur
		: (vcur < 0 ? -$signed({1'b0, qv_q}) : $signed({1'b0, qv_q}));

	assign eax_t = (cmd.idx == 2'd0) ? -prod_q : prod_q;
	assign isum  = 22'(integ_q[cmd.idx]) + 22'(prod_q >>> 13);
	assign inext = (isum > 22'(INTEG_MAX)) ? INTEG_MAX
		: ((isum < -22'(INTEG_MAX)) ? -INTEG_MAX : isum[19:0]);
	assign dsh    = 39'(acc_q >>> 23);
	assign dclamp = (dsh > 39'(DRIVE_MAX)) ? DRIVE_MAX
		: ((dsh < -39'(DRIVE_MAX)) ? -DRIVE_MAX : dsh[15:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q[0] <= 16'sd16384;
			tgt_q[1] <= 16'sd16384;
			tgt_q[2] <= 16'sd16384;
			gp_q     <= 16'd4096;
			gi_q     <= 16'd205;
			gd_q     <= 16'd1229;
			tl_q     <= 16'd655;
			tr_q     <= 24'd25600;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TARGET_X:    tgt_q[0] <= cfg_data[15:0];
				REG_TARGET_Y:    tgt_q[1] <= cfg_data[15:0];
				REG_TARGET_Z:    tgt_q[2] <= cfg_data[15:0];
				REG_GAIN_PROP:   gp_q <= cfg_data[15:0];
				REG_GAIN_INTEG:  gi_q <= cfg_data[15:0];
				REG_GAIN_DERIV:  gd_q <= cfg_data[15:0];
				REG_TICK_LENGTH: tl_q <= cfg_data[15:0];
				REG_TICK_RATE:   tr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				integ_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else begin
			if (cmd.op == OP_IUPD) begin
				integ_q[cmd.idx] <= inext;
			end
			if (cmd.op == OP_DMUL) begin
				last_q[cmd.idx] <= ax_q[cmd.idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load_in) begin
			for (int i = 0; i < 3; i++) begin
				vin_q[i] <= axis_in[i];
			end
		end
		if (cmd.load_out) begin
			for (int i = 0; i < 3; i++) begin
				out_q[i] <= drv_q[i];
			end
		end
		case (cmd.op)
			OP_NINIT: s_q <= '0;
			OP_SQW: begin
				sq_q[cmd.idx] <= prod_q[30:0];
				s_q           <= s_q + prod_q[31:0];
			end
			OP_CINIT: begin
				num_q <= {sq_q[cmd.idx], 28'd0};
				p_q   <= '0;
				qs_q  <= '0;
				qv_q  <= '0;
			end
			OP_CBIT: begin
				if (take) begin
					p_q  <= c2s[61:0];
					qs_q <= qs_q + 48'({16'd0, s_q} << cmd.bitn);
					qv_q <= qv_q | (15'd1 << cmd.bitn);
				end
			end
			OP_CSTORE: begin
				if (cmd.vsel) begin
					cn_q[cmd.idx] <= nval;
				end else begin
					tn_q[cmd.idx] <= nval;
				end
			end
			OP_EAX:   ax_q[cmd.idx] <= 18'(eax_t >>> 14);
			OP_PACC:  acc_q <= prod_q <<< 8;
			OP_GACC:  acc_q <= acc_q + (prod_q <<< 5);
			OP_MSAVE: m_q <= prod_q[35:0];
			OP_RACC0: acc_q <= acc_q + prod_q;
			OP_RACC1: acc_q <= acc_q + (prod_q <<< 12);
			OP_DOUT:  drv_q[cmd.idx] <= dclamp;
			default: ;
		endcase
	end

	assign drive_val = out_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the three-axis attitude PID unit.
`timescale 1ns / 100ps

module testbench;
	import tapid_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int RANDOM_ITEMS = 1750;

	typedef struct {
		logic signed [15:0] x, y, z;
		bit                 typed;
		logic signed [15:0] ex, ey, ez;
	} dir_row_t;

	typedef struct {
		logic signed [15:0] x, y, z;
	} volts_t;

	typedef struct {
		bit     typed;
		volts_t v;
	} typed_t;

	logic clk;
	logic arst_n;

	tapid_in_if  meas ();
	tapid_out_if drive ();
	tapid_cfg_if cfg ();

	three_axis_attitude_pid_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.meas   (meas),
		.drive  (drive),
		.cfg    (cfg)
	);

	// register copy
	logic signed [15:0] targ_x, targ_y, targ_z;
	logic [15:0]        kp, ki, kd, dt;
	logic [23:0]        inv_dt;
	// lane state
	longint             integ[3];
	longint             prev_err[3];

	volts_t expected_drive[$];
	typed_t typed_q[$];

	int  mismatches = 0;
	int  errors = 0;
	int  accepted = 0;
	int  cycles = 0;
	bit  calm = 0;
	bit  hold_off = 0;
	int  stall_left = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic void unit_vec(input longint v0, v1, v2,
			output longint n0, n1, n2);
		longint v[3];
		longint n[3];
		longint unsigned s, a, num, q, c;
		v[0] = v0;
		v[1] = v1;
		v[2] = v2;
		s = v0 * v0 + v1 * v1 + v2 * v2;
		for (int i = 0; i < 3; i++) begin
			if (s == 0) begin
				n[i] = v[i];
			end else begin
				a = v[i] < 0 ? -v[i] : v[i];
				num = (a * a) << 28;
				q = 0;
				for (int b = 14; b >= 0; b--) begin
					c = q | (64'd1 << b);
					if (c * c * s <= num)
						q = c;
				end
				n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
		n0 = n[0];
		n1 = n[1];
		n2 = n[2];
	endfunction

	function automatic volts_t step_pid(input logic signed [15:0] cx, cy, cz);
		longint tn[3], cn[3], e[3], ax[3];
		longint inc, der, acc, v;
		volts_t r;
		logic signed [15:0] o[3];
		unit_vec(targ_x, targ_y, targ_z, tn[0], tn[1], tn[2]);
		unit_vec(cx, cy, cz, cn[0], cn[1], cn[2]);
		for (int i = 0; i < 3; i++)
			e[i] = tn[i] - cn[i];
		ax[0] = (-(e[1] * e[2])) >>> 14;
		ax[1] = (e[2] * e[0]) >>> 14;
		ax[2] = (e[0] * e[1]) >>> 14;
		for (int i = 0; i < 3; i++) begin
			inc = (ax[i] * longint'(dt)) >>> 13;
			integ[i] = integ[i] + inc;
			if (integ[i] > 262144)
				integ[i] = 262144;
			if (integ[i] < -262144)
				integ[i] = -262144;
			der = (ax[i] - prev_err[i]) * longint'(inv_dt);
			prev_err[i] = ax[i];
			acc = longint'(kp) * ax[i] * 256 + longint'(ki) * integ[i] * 32
				+ longint'(kd) * der;
			v = acc >>> 23;
			if (v > 20480)
				v = 20480;
			if (v < -20480)
				v = -20480;
			o[i] = v[15:0];
		end
		r.x = o[0];
		r.y = o[1];
		r.z = o[2];
		return r;
	endfunction

	// input side: register model, prediction
	always @(posedge clk or negedge arst_n) begin
		volts_t p;
		typed_t t;
		if (!arst_n) begin
			targ_x <= 16'sd16384;
			targ_y <= 16'sd16384;
			targ_z <= 16'sd16384;
			kp <= 16'd4096;
			ki <= 16'd205;
			kd <= 16'd1229;
			dt <= 16'd655;
			inv_dt <= 24'd25600;
			for (int i = 0; i < 3; i++) begin
				integ[i] = 0;
				prev_err[i] = 0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				REG_TARGET_X:    targ_x <= cfg.data[15:0];
				REG_TARGET_Y:    targ_y <= cfg.data[15:0];
				REG_TARGET_Z:    targ_z <= cfg.data[15:0];
				REG_GAIN_PROP:   kp <= cfg.data[15:0];
				REG_GAIN_INTEG:  ki <= cfg.data[15:0];
				REG_GAIN_DERIV:  kd <= cfg.data[15:0];
				REG_TICK_LENGTH: dt <= cfg.data[15:0];
				REG_TICK_RATE:   inv_dt <= cfg.data;
				default: ;
				endcase
			end
			if (meas.valid && meas.ready) begin
				p = step_pid(meas.axis_x, meas.axis_y, meas.axis_z);
				t = typed_q.pop_front();
				expected_drive.push_back(t.typed ? t.v : p);
				accepted++;
			end
		end
	end

	// output side: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		volts_t want;
		if (arst_n && drive.valid && drive.ready) begin
			if (expected_drive.size() == 0) begin
				errors++;
				if (mismatches < 10)
					$display("unexpected drive transfer %0d %0d %0d",
						drive.drive_x, drive.drive_y, drive.drive_z);
				mismatches++;
			end else begin
				want = expected_drive.pop_front();
				if (drive.drive_x !== want.x || drive.drive_y !== want.y ||
						drive.drive_z !== want.z) begin
					errors++;
					if (mismatches < 10)
						$display("drive mismatch: expected %0d %0d %0d, got %0d %0d %0d",
							want.x, want.y, want.z,
							drive.drive_x, drive.drive_y, drive.drive_z);
					mismatches++;
				end
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		int r;
		if (hold_off) begin
			drive.ready <= 1'b0;
		end else if (stall_left > 0) begin
			drive.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			drive.ready <= 1'b1;
			r = $urandom_range(0, 99);
			if (!calm && r < 25)
				stall_left <= (r < 3) ? $urandom_range(20, 150) : $urandom_range(1, 3);
		end
	end

	// long hold-off so the block fills and stalls its input
	initial begin
		while (accepted < 400)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (1500) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic offer_axis(input logic signed [15:0] x, y, z, input typed_t t);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		gap = calm ? 0 : (r < 60 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 80)));
		if (gap > 0) begin
			meas.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_q.push_back(t);
		meas.valid <= 1'b1;
		meas.axis_x <= x;
		meas.axis_y <= y;
		meas.axis_z <= z;
		do
			@(negedge clk);
		while (!meas.ready);
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do
			@(negedge clk);
		while (!cfg.ready);
		@(posedge clk);
	endtask

	task automatic drain;
		meas.valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_regs(input logic [15:0] tx, ty, tz, gp, gi, gd, tl,
			input logic [23:0] tr);
		write_reg(REG_TARGET_X, {8'd0, tx});
		write_reg(REG_TARGET_Y, {8'd0, ty});
		write_reg(REG_TARGET_Z, {8'd0, tz});
		write_reg(REG_GAIN_PROP, {8'd0, gp});
		write_reg(REG_GAIN_INTEG, {8'd0, gi});
		write_reg(REG_GAIN_DERIV, {8'd0, gd});
		write_reg(REG_TICK_LENGTH, {8'd0, tl});
		write_reg(REG_TICK_RATE, tr);
		cfg.valid <= 1'b0;
	endtask

	task automatic random_axis(output logic signed [15:0] x, y, z);
		int r;
		r = $urandom_range(0, 99);
		x = 16'($urandom);
		y = 16'($urandom);
		z = 16'($urandom);
		if (r < 20) begin
			x = 16'($signed($urandom_range(0, 128)) - 64);
			y = 16'($signed($urandom_range(0, 128)) - 64);
			z = 16'($signed($urandom_range(0, 128)) - 64);
		end else if (r < 40) begin
			x = 16'(targ_x + $signed($urandom_range(0, 2000)) - 1000);
			y = 16'(targ_y + $signed($urandom_range(0, 2000)) - 1000);
			z = 16'(targ_z + $signed($urandom_range(0, 2000)) - 1000);
		end else if (r < 50) begin
			if ($urandom_range(0, 1)) x = 0;
			if ($urandom_range(0, 1)) y = 0;
			if ($urandom_range(0, 1)) z = 0;
		end else if (r < 55) begin
			x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			z = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		end
	endtask

	dir_row_t rows[17] = '{
		'{16384, 16384, 16384, 1, 0, 0, 0},
		'{32767, 32767, 32767, 1, 0, 0, 0},
		'{8192, 8192, 8192, 1, 0, 0, 0},
		'{-32768, -32768, -32768, 0, 0, 0, 0},
		'{0, 0, 0, 0, 0, 0, 0},
		'{32767, 0, 0, 0, 0, 0, 0},
		'{-32768, 0, 0, 0, 0, 0, 0},
		'{0, 32767, 0, 0, 0, 0, 0},
		'{0, -32768, 0, 0, 0, 0, 0},
		'{0, 0, 32767, 0, 0, 0, 0},
		'{0, 0, -32768, 0, 0, 0, 0},
		'{1, 0, 0, 0, 0, 0, 0},
		'{-1, -1, -1, 0, 0, 0, 0},
		'{1, -1, 1, 0, 0, 0, 0},
		'{-32768, 32767, -32768, 0, 0, 0, 0},
		'{21845, -10923, 5461, 0, 0, 0, 0},
		'{16384, 16384, 16384, 0, 0, 0, 0}
	};

	initial begin
		typed_t t;
		logic signed [15:0] x, y, z;
		int phase;
		arst_n = 1'b0;
		meas.valid = 1'b0;
		meas.axis_x = '0;
		meas.axis_y = '0;
		meas.axis_z = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		drive.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			t.typed = rows[i].typed;
			t.v.x = rows[i].ex;
			t.v.y = rows[i].ey;
			t.v.z = rows[i].ez;
			offer_axis(rows[i].x, rows[i].y, rows[i].z, t);
		end

		t.typed = 0;
		t.v = '{0, 0, 0};
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 250 == 0) begin
				drain();
				phase = k / 250;
				case (phase)
				0: ;
				1: load_regs(16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'hffff, 16'hffff,
					16'hffff, 24'hffffff);
				2: load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
					16'h0001, 24'h000001);
				3: load_regs(16'h4000, 16'h0000, 16'h0000, 16'd4096, 16'd205, 16'd1229,
					16'd655, 24'd25600);
				default: load_regs(16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(1, 65535)), 24'($urandom_range(1, 16777215)));
				endcase
			end
			calm = ((k / 100) % 4) == 3;
			random_axis(x, y, z);
			offer_axis(x, y, z, t);
		end
		meas.valid <= 1'b0;
		while (expected_drive.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tapid_pkg.sv
rtl/tapid_if.sv
rtl/tapid_ctrl.sv
rtl/tapid_dp.sv
rtl/three_axis_attitude_pid_unit.sv
sim/testbench.sv
